// ===== hw/rtl/hmr_pkg.sv =====
// Shared constants and types for the min-heap replace-top block.
package hmr_pkg;

	localparam int HMR_MAX_ENTRIES = 256;
	localparam int VAL_W           = 64;
	localparam int HSIZE_W         = 9;
	localparam int CFG_IDX_W       = 1;

	localparam logic KIND_REPLACE = 1'b0;
	localparam logic KIND_CLEAR   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 1'b1;

	localparam logic [HSIZE_W-1:0] HSIZE_RST = 9'd256;
	localparam logic [VAL_W-1:0]   FILL_RST  = 64'd0;

	typedef struct packed {
		logic signed [VAL_W-1:0] current_min;
		logic signed [VAL_W-1:0] evicted_min;
	} hmr_res_t;

endpackage

// ===== hw/rtl/hmr_mem.sv =====
// Heap store: one write port, two registered read ports.
module hmr_mem import hmr_pkg::*; #(
	parameter int DEPTH = HMR_MAX_ENTRIES,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [VAL_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [VAL_W-1:0] rd_data_a,
	output logic [VAL_W-1:0] rd_data_b
);

	logic [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// ===== hw/rtl/hmr_ctrl.sv =====
// Sequencer: reset sweep, clear sweep and sift-down over the heap store.
module hmr_ctrl import hmr_pkg::*; #(
	parameter int MAX_ENTRIES = HMR_MAX_ENTRIES,
	parameter int AW          = 8,
	parameter int PW          = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_kind,
	input  logic signed [VAL_W-1:0]    in_value,
	input  logic [HSIZE_W-1:0]         heap_size,
	input  logic signed [VAL_W-1:0]    fill_value,
	output logic                       res_valid,
	input  logic                       res_ready,
	output hmr_res_t                   res,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [VAL_W-1:0]           wr_data,
	output logic [AW-1:0]              rd_addr_a,
	output logic [AW-1:0]              rd_addr_b,
	input  logic [VAL_W-1:0]           rd_data_a,
	input  logic [VAL_W-1:0]           rd_data_b
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CLR  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]              state_q;
	logic [AW-1:0]           idx_q;
	logic [PW-1:0]           pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] old_q;
	logic signed [VAL_W-1:0] root_q;

	logic [31:0]             hs_ext;
	logic [PW-1:0]           n_act;
	logic [PW-1:0]           lc;
	logic [PW-1:0]           rc;
	logic                    pick_l;
	logic                    pick_r;
	logic signed [VAL_W-1:0] left_v;
	logic signed [VAL_W-1:0] right_v;
	logic signed [VAL_W-1:0] cur_v;
	logic                    sweep_last;

	always_comb begin
		hs_ext = 32'(heap_size);
		if (hs_ext == 32'd0) begin
			n_act = PW'(1);
		end else if (hs_ext > 32'(MAX_ENTRIES)) begin
			n_act = PW'(MAX_ENTRIES);
		end else begin
			n_act = PW'(hs_ext);
		end
	end

	assign lc      = pos_q << 1;
	assign rc      = lc | PW'(1);
	assign left_v  = $signed(rd_data_a);
	assign right_v = $signed(rd_data_b);
	assign pick_l  = (lc <= n_act) && (left_v < val_q);
	assign cur_v   = pick_l ? left_v : val_q;
	assign pick_r  = (rc <= n_act) && (right_v < cur_v);
	assign sweep_last = (PW'(idx_q) + PW'(1)) == n_act;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign res.evicted_min = old_q;
	assign res.current_min = root_q;

	assign rd_addr_a = AW'(lc - PW'(1));
	assign rd_addr_b = AW'(lc);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(pos_q - PW'(1));
		wr_data = val_q;
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = FILL_RST;
			end
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = fill_value;
			end
			ST_CMP: begin
				wr_en = 1'b1;
				if (pick_r) begin
					wr_data = right_v;
				end else if (pick_l) begin
					wr_data = left_v;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			idx_q   <= '0;
			pos_q   <= PW'(1);
			root_q  <= FILL_RST;
		end else begin
			if (wr_en && wr_addr == '0) begin
				root_q <= wr_data;
			end
			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == AW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						pos_q <= PW'(1);
						state_q <= (in_kind == KIND_CLEAR) ? ST_CLR : ST_RD;
					end
				end
				ST_CLR: begin
					idx_q <= idx_q + AW'(1);
					if (sweep_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pick_r) begin
						pos_q   <= rc;
						state_q <= ST_RD;
					end else if (pick_l) begin
						pos_q   <= lc;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			old_q <= root_q;
			val_q <= in_value;
		end
	end

endmodule

// ===== hw/rtl/min_heap_replace_top_unit.sv =====
// Top level of the min-heap replace-top block: config registers, result register.
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tdata value, s_tuser kind
//  m_*      out        m_tvalid / m_tready    m_tdata evicted_min, current_min
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Replace: per heap level, read both children, then compare and write back; up to
// log2(MAX_ENTRIES)+1 levels, then the result.
// Clear: one store write per active entry, then the result.
// After reset the store is swept to zero, with s_tready low until the sweep is done.
// A stalled result waits in the output register while the next item is taken.
module min_heap_replace_top_unit import hmr_pkg::*; #(
	parameter int MAX_ENTRIES = HMR_MAX_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VAL_W-1:0]       s_tdata,   // [63:0] value
	input  logic [0:0]             s_tuser,   // [0] kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [2*VAL_W-1:0]     m_tdata,   // [63:0] evicted_min, [127:64] current_min
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [VAL_W-1:0]       cfg_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PW = $clog2(2 * MAX_ENTRIES + 2);

	logic [HSIZE_W-1:0]      heap_size_q;
	logic signed [VAL_W-1:0] fill_value_q;
	logic                    res_valid;
	logic                    res_ready;
	hmr_res_t                res;
	logic                    m_tvalid_q;
	hmr_res_t                m_res_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [VAL_W-1:0]        wr_data;
	logic [AW-1:0]           rd_addr_a;
	logic [AW-1:0]           rd_addr_b;
	logic [VAL_W-1:0]        rd_data_a;
	logic [VAL_W-1:0]        rd_data_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q  <= HSIZE_RST;
			fill_value_q <= FILL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEAP_SIZE:  heap_size_q  <= cfg_data[HSIZE_W-1:0];
				CFG_FILL_VALUE: fill_value_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hmr_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.PW          (PW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser[0]),
		.in_value   (s_tdata),
		.heap_size  (heap_size_q),
		.fill_value (fill_value_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.rd_data_a  (rd_data_a),
		.rd_data_b  (rd_data_b)
	);

	hmr_mem #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_res_q;

endmodule

// ===== hw/rtl/hmr_chk.sv =====
// Port-level checker for the min-heap replace-top block, bound to the top level.
module hmr_chk import hmr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [2*VAL_W-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input ready stayed high after a transaction");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result shown with no item outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q != 2'd2)
		else $error("item taken with two results outstanding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind min_heap_replace_top_unit hmr_chk u_hmr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/min_heap_replace_checker.sv =====
`timescale 1ns / 100ps
// Checker for the min-heap replace-top block: predicts root pairs and compares results.
module min_heap_replace_checker import hmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [VAL_W-1:0]     s_tdata,   // [63:0] value
	input  logic [0:0]           s_tuser,   // [0] kind
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [2*VAL_W-1:0]   m_tdata,   // [63:0] evicted_min, [127:64] current_min
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	logic signed [VAL_W-1:0] heap_mem [1:HMR_MAX_ENTRIES];
	logic [HSIZE_W-1:0]      heap_size_r;
	logic signed [VAL_W-1:0] fill_r;
	hmr_res_t                root_pairs_q [$];
	int                      mismatches;

	function automatic int active_entries();
		if (heap_size_r == '0) return 1;
		if (heap_size_r > HMR_MAX_ENTRIES) return HMR_MAX_ENTRIES;
		return int'(heap_size_r);
	endfunction

	task automatic apply_heap_item(input logic kind, input logic signed [VAL_W-1:0] val,
			output hmr_res_t res);
		int n;
		int pos;
		int pick;
		int lc;
		bit settled;
		logic signed [VAL_W-1:0] tmp;
		n = active_entries();
		res.evicted_min = heap_mem[1];
		if (kind == KIND_CLEAR) begin
			for (int i = 1; i <= n; i++) heap_mem[i] = fill_r;
		end else begin
			heap_mem[1] = val;
			pos = 1;
			settled = 1'b0;
			while (!settled) begin
				lc = 2 * pos;
				pick = pos;
				if (lc <= n && heap_mem[lc] < heap_mem[pos]) pick = lc;
				if (lc + 1 <= n && heap_mem[lc + 1] < heap_mem[pick]) pick = lc + 1;
				if (pick == pos) begin
					settled = 1'b1;
				end else begin
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[pick];
					heap_mem[pick] = tmp;
					pos = pick;
				end
			end
		end
		res.current_min = heap_mem[1];
	endtask

	always @(posedge clk or negedge arst_n) begin
		hmr_res_t got;
		hmr_res_t want;
		if (!arst_n) begin
			for (int i = 1; i <= HMR_MAX_ENTRIES; i++) heap_mem[i] = FILL_RST;
			heap_size_r = HSIZE_RST;
			fill_r = FILL_RST;
			root_pairs_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HEAP_SIZE) heap_size_r = cfg_data[HSIZE_W-1:0];
				else if (cfg_index == CFG_FILL_VALUE) fill_r = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				apply_heap_item(s_tuser[0], s_tdata, want);
				root_pairs_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = hmr_res_t'(m_tdata);
				if (root_pairs_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: expected none, actual evicted_min %0d current_min %0d",
						$time, got.evicted_min, got.current_min);
				end else begin
					want = root_pairs_q.pop_front();
					if (got.evicted_min !== want.evicted_min) begin
						mismatches++;
						$display("%0t: evicted_min expected %0d actual %0d",
							$time, want.evicted_min, got.evicted_min);
					end
					if (got.current_min !== want.current_min) begin
						mismatches++;
						$display("%0t: current_min expected %0d actual %0d",
							$time, want.current_min, got.current_min);
					end
				end
			end
		end
		fail_count <= mismatches;
		pending <= root_pairs_q.size();
	end

endmodule

// ===== tb/tb_min_heap_replace_top_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the min-heap replace-top block: stimulus, idling and verdict.
module tb_min_heap_replace_top_unit;
	import hmr_pkg::*;

	localparam int IDLE_LIMIT      = 4000;
	localparam int PHASES          = 20;
	localparam int ITEMS_PER_PHASE = 85;
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [VAL_W-1:0]     s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [2*VAL_W-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0]     cfg_data = '0;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int stall_left = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;

	min_heap_replace_top_unit uut (.*);

	min_heap_replace_checker heap_chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value();
		int small_v;
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3, 4: begin
				small_v = $urandom_range(0, 15);
				return VAL_W'(small_v - 8);
			end
			5, 6, 7: return {$urandom, $urandom};
			default: begin
				small_v = $urandom;
				return VAL_W'(small_v);
			end
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] size_word(input int sz);
		logic [VAL_W-1:0] w;
		w = {$urandom, $urandom};
		w[HSIZE_W-1:0] = sz[HSIZE_W-1:0];
		return w;
	endfunction

	task automatic send_item(input logic kind, input logic [VAL_W-1:0] val);
		int gap;
		cfg_valid <= 1'b0;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	// after each transaction, pick a random stall (possibly none) before taking the next result
	always @(posedge clk or negedge arst_n) begin
		int gap_len;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (m_tvalid && m_tready) begin
			gap_len = pick_gap(sink_calm);
			m_tready <= (gap_len == 0);
			stall_left <= (gap_len > 0) ? gap_len - 1 : 0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int sz;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_item(KIND_REPLACE, VAL_MAX);
		send_item(KIND_REPLACE, VAL_MIN);
		send_item(KIND_REPLACE, 64'sd0);
		send_item(KIND_REPLACE, -64'sd1);
		send_item(KIND_REPLACE, 64'sd1);
		send_item(KIND_CLEAR, {$urandom, $urandom});
		send_item(KIND_REPLACE, 64'sd5);
		send_item(KIND_REPLACE, 64'sd5);

		wait_idle();
		write_reg(CFG_HEAP_SIZE, size_word(1));
		write_reg(CFG_FILL_VALUE, VAL_MAX);
		send_item(KIND_CLEAR, VAL_MIN);
		send_item(KIND_REPLACE, VAL_MIN);
		send_item(KIND_REPLACE, VAL_MAX);

		wait_idle();
		write_reg(CFG_HEAP_SIZE, size_word(0));
		send_item(KIND_REPLACE, 64'sd7);
		send_item(KIND_REPLACE, -64'sd7);

		// grow past the capacity: entries beyond the old size keep their contents
		wait_idle();
		write_reg(CFG_HEAP_SIZE, size_word(511));
		write_reg(CFG_FILL_VALUE, VAL_MIN);
		send_item(KIND_REPLACE, VAL_MAX);
		send_item(KIND_CLEAR, VAL_MAX);
		send_item(KIND_REPLACE, VAL_MIN);
		send_item(KIND_REPLACE, 64'sd0);

		wait_idle();
		write_reg(CFG_HEAP_SIZE, size_word(3));
		write_reg(CFG_FILL_VALUE, 64'sd0);
		send_item(KIND_CLEAR, VAL_MAX);
		send_item(KIND_REPLACE, 64'sd2);
		send_item(KIND_REPLACE, 64'sd2);
		send_item(KIND_REPLACE, -64'sd1);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case ($urandom_range(0, 7))
				0: sz = 0;
				1: sz = 1;
				2: sz = $urandom_range(2, 7);
				3: sz = HMR_MAX_ENTRIES;
				4: sz = $urandom_range(HMR_MAX_ENTRIES + 1, 511);
				default: sz = $urandom_range(2, HMR_MAX_ENTRIES - 1);
			endcase
			write_reg(CFG_HEAP_SIZE, size_word(sz));
			if ($urandom_range(0, 1) == 1) write_reg(CFG_FILL_VALUE, rand_value());
			src_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				send_item(($urandom_range(0, 24) == 0) ? KIND_CLEAR : KIND_REPLACE, rand_value());
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/hmr_pkg.sv
hw/rtl/hmr_mem.sv
hw/rtl/hmr_ctrl.sv
hw/rtl/min_heap_replace_top_unit.sv
hw/rtl/hmr_chk.sv
tb/min_heap_replace_checker.sv
tb/tb_min_heap_replace_top_unit.sv
